// ===== rtl/cft_pkg.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer package
// Shared types, register codes, parser states and error codes.
// ----------------------------------------------------------------------------
package cft_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUOTE_MARK = 1'b1;

    localparam logic [7:0] DELIMITER_RST  = 8'd44;
    localparam logic [7:0] QUOTE_MARK_RST = 8'd34;
    localparam logic [7:0] LINE_FEED      = 8'd10;
    localparam logic [7:0] NUL_BYTE       = 8'd0;

    // error codes
    localparam logic [1:0] ERR_NONE          = 2'd0;
    localparam logic [1:0] ERR_UNEXP_CHAR    = 2'd1;
    localparam logic [1:0] ERR_UNEXP_QUOTE   = 2'd2;
    localparam logic [1:0] ERR_MISSING_QUOTE = 2'd3;

    typedef enum logic [4:0] {
        ST_BEFORE   = 5'b00001,
        ST_QUOTED   = 5'b00010,
        ST_AFTERQ   = 5'b00100,
        ST_UNQUOTED = 5'b01000,
        ST_AFTERD   = 5'b10000
    } parse_state_t;

    typedef struct packed {
        logic [7:0] delimiter;
        logic [7:0] quote_mark;
    } cfg_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [1:0] error_code;
        logic       field_begin;
        logic [1:0] char_count;
        logic [7:0] first_char;
        logic [7:0] second_char;
        logic       field_end;
        logic       record_end;
    } out_item_t;

endpackage

// ===== rtl/cft_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer configuration registers
// Delimiter and quote mark, written through a plain write port.
// ----------------------------------------------------------------------------
module cft_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [cft_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cft_pkg::CFG_DATA_W-1:0] cfg_data,
    output cft_pkg::cfg_t                 cfg
);
    import cft_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_DELIMITER:  cfg_next.delimiter  = cfg_data;
                CFG_QUOTE_MARK: cfg_next.quote_mark = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delimiter  <= DELIMITER_RST;
            cfg_reg.quote_mark <= QUOTE_MARK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/cft_step.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer step logic
// Decodes one byte against the parser state: result item and next state.
// ----------------------------------------------------------------------------
module cft_step (
    input  cft_pkg::parse_state_t state,
    input  cft_pkg::cfg_t         cfg,
    input  cft_pkg::in_item_t     item,
    output cft_pkg::out_item_t    res,
    output cft_pkg::parse_state_t state_next
);
    import cft_pkg::*;

    logic [7:0] c;
    logic       is_delim;
    logic       is_quote;
    logic       is_lf;
    logic       is_stop;

    assign c        = item.in_byte;
    assign is_delim = (c == cfg.delimiter);
    assign is_quote = (c == cfg.quote_mark);
    assign is_lf    = (c == LINE_FEED);
    assign is_stop  = item.end_of_stream || (c == NUL_BYTE);

    always_comb
    begin
        res        = '0;
        state_next = state;
        if (is_stop)
        begin
            // close whatever field is open, then end the record
            case (state)
                ST_QUOTED:
                begin
                    res.error_code = ERR_MISSING_QUOTE;
                    res.field_end  = 1'b1;
                end
                ST_AFTERQ, ST_UNQUOTED: res.field_end = 1'b1;
                ST_AFTERD:
                begin
                    res.field_begin = 1'b1;
                    res.field_end   = 1'b1;
                end
                default: res.field_end = 1'b0;
            endcase
            res.record_end = 1'b1;
            state_next     = ST_BEFORE;
        end
        else
        begin
            case (state)
                ST_QUOTED:
                begin
                    if (is_quote)
                        state_next = ST_AFTERQ;
                    else
                    begin
                        res.char_count = 2'd1;
                        res.first_char = c;
                    end
                end
                ST_AFTERQ:
                begin
                    if (is_quote)
                    begin
                        // doubled quote is one literal quote
                        res.char_count = 2'd1;
                        res.first_char = c;
                        state_next     = ST_QUOTED;
                    end
                    else if (is_delim)
                    begin
                        res.field_end = 1'b1;
                        state_next    = ST_AFTERD;
                    end
                    else if (is_lf)
                    begin
                        res.field_end  = 1'b1;
                        res.record_end = 1'b1;
                        state_next     = ST_BEFORE;
                    end
                    else
                    begin
                        res.error_code  = ERR_UNEXP_CHAR;
                        res.char_count  = 2'd2;
                        res.first_char  = cfg.quote_mark;
                        res.second_char = c;
                        state_next      = ST_UNQUOTED;
                    end
                end
                ST_UNQUOTED:
                begin
                    if (is_delim)
                    begin
                        res.field_end = 1'b1;
                        state_next    = ST_AFTERD;
                    end
                    else if (is_lf)
                    begin
                        res.field_end  = 1'b1;
                        res.record_end = 1'b1;
                        state_next     = ST_BEFORE;
                    end
                    else
                    begin
                        res.error_code = is_quote ? ERR_UNEXP_QUOTE : ERR_NONE;
                        res.char_count = 2'd1;
                        res.first_char = c;
                    end
                end
                default:
                begin
                    // before field, after delimiter
                    if (is_delim)
                    begin
                        res.field_begin = 1'b1;
                        res.field_end   = 1'b1;
                        state_next      = ST_AFTERD;
                    end
                    else if (is_lf)
                    begin
                        // trailing delimiter leaves one empty field
                        res.field_begin = (state == ST_AFTERD);
                        res.field_end   = (state == ST_AFTERD);
                        res.record_end  = 1'b1;
                        state_next      = ST_BEFORE;
                    end
                    else if (is_quote)
                    begin
                        res.field_begin = 1'b1;
                        state_next      = ST_QUOTED;
                    end
                    else
                    begin
                        res.field_begin = 1'b1;
                        res.char_count  = 2'd1;
                        res.first_char  = c;
                        state_next      = ST_UNQUOTED;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/csv_field_tokenizer.sv =====
// Pipeline: a byte request is registered at the input, decoded combinationally
// and its result is registered at the output.
// Throughput: one byte per cycle unless the output stalls; the parser state
// updates as a byte moves from the input register to the output register.
// Reset: parser back to before-field, both registers empty, delimiter ','
// and quote mark '"'.
// ----------------------------------------------------------------------------
// CSV field tokenizer
// Byte-serial CSV record parser with configurable delimiter and quote mark.
// ----------------------------------------------------------------------------
module csv_field_tokenizer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [cft_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cft_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           byte_valid,
    output logic                           byte_stall,
    input  cft_pkg::in_item_t              byte_data,
    output logic                           result_valid,
    input  logic                           result_stall,
    output cft_pkg::out_item_t             result_data
);
    import cft_pkg::*;

    cfg_t         cfg;
    parse_state_t state_reg;
    parse_state_t state_next;
    in_item_t     in_data_reg;
    logic         in_valid_reg;
    logic         in_valid_next;
    out_item_t    out_data_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    out_item_t    step_res;
    logic         out_free;
    logic         in_move;
    logic         in_take;

    cft_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cft_step u_step (
        .state      (state_reg),
        .cfg        (cfg),
        .item       (in_data_reg),
        .res        (step_res),
        .state_next (state_next)
    );

    assign out_free = !out_valid_reg || !result_stall;
    assign in_move  = in_valid_reg && out_free;
    // input register frees up when its byte moves on
    assign byte_stall = in_valid_reg && !out_free;
    assign in_take    = byte_valid && !byte_stall;

    assign in_valid_next  = in_take || (in_valid_reg && !in_move);
    assign out_valid_next = in_move || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_BEFORE;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_move)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_data_reg <= byte_data;
        if (in_move)
            out_data_reg <= step_res;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    a_rec_end_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
        (in_move && step_res.record_end) |=> (state_reg == ST_BEFORE))
        else $error("record end did not return parser to start");

    a_char_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.char_count != 2'd3))
        else $error("char count out of range");

    a_missing_quote_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.error_code == ERR_MISSING_QUOTE)
        |-> (result_data.field_end && result_data.record_end))
        else $error("missing quote without field and record end");

    a_empty_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !byte_stall)
        else $error("input stalled with empty input register");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(in_move) |-> $stable(state_reg))
        else $error("parser state changed without a byte");

endmodule
